[rtl/chained_block_allocation_table_defines.svh]
// ----------------------------------------------------------------------------
// Chained block allocation table: assertion macros
// Concurrent checks on the rising edge of clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAINED_BLOCK_ALLOCATION_TABLE_DEFINES_SVH
`define CHAINED_BLOCK_ALLOCATION_TABLE_DEFINES_SVH

// same-cycle implication
`define CBAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cbat_pkg.sv]
// ----------------------------------------------------------------------------
// cbat_pkg
// Shared constants, codes and types of the chained block allocation table.
// ----------------------------------------------------------------------------
package cbat_pkg;

    localparam int NUM_BLOCKS_DEF = 256;
    localparam int MAX_BLOCKS     = 256;
    localparam int CNT_W          = 9;
    localparam int IDX_W          = 8;
    localparam int OP_W           = 2;
    localparam int ST_W           = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_END,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_FIN,
        S_READ_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] block_count;
        logic [IDX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] result_block;
        logic             chain_end;
        logic [CNT_W-1:0] blocks_freed;
        logic [CNT_W-1:0] free_left;
    } res_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic res_take;
    } ctl_t;

endpackage

[rtl/cbat_core.sv]
// ----------------------------------------------------------------------------
// cbat_core
// Link RAM, used flags, free count and the sequencer that allocates, frees
// and reads chains. One request at a time; operations never overlap in RAM.
// ----------------------------------------------------------------------------
module cbat_core
    import cbat_pkg::*;
#(
    parameter int  NUM_BLOCKS = NUM_BLOCKS_DEF,
    localparam int MEM_DEPTH  = (NUM_BLOCKS < MAX_BLOCKS) ? NUM_BLOCKS : MAX_BLOCKS,
    localparam int NW         = $clog2(MEM_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctl_t          ctl,
    input  req_t          req,
    input  logic [NW-1:0] clear_blocks,
    input  logic [NW-1:0] blocks,
    output logic          idle,
    output logic          res_valid,
    output res_t          res
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic [AW:0] mem [MEM_DEPTH];
    logic [AW:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [MEM_DEPTH-1:0] used_reg, used_next;
    logic [NW-1:0]        free_reg, free_next;
    logic [NW-1:0]        scan_reg, scan_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 have_reg, have_next;
    logic [AW-1:0]        prev_reg, prev_next;
    logic [AW-1:0]        start_reg, start_next;
    logic [AW-1:0]        cur_reg, cur_next;
    logic [NW-1:0]        freed_reg, freed_next;
    res_t                 res_reg, res_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] req_idx;
    logic [AW-1:0] scan_idx;
    logic          req_ok;
    logic [NW:0]   free_sum;
    logic [NW-1:0] free_clamp;

    assign req_idx  = req.block_index[AW-1:0];
    assign scan_idx = scan_reg[AW-1:0];
    assign req_ok   = (CNT_W'(req.block_index) < CNT_W'(blocks)) && used_reg[req_idx];
    assign free_sum = (NW+1)'(free_reg) + (NW+1)'(freed_reg);
    assign free_clamp = (free_sum > (NW+1)'(blocks)) ? blocks : free_sum[NW-1:0];
    assign rd_addr  = (state_reg == S_IDLE) ? req_idx : cur_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            free_reg  <= NW'(MEM_DEPTH);
            scan_reg  <= '0;
            left_reg  <= '0;
            have_reg  <= 1'b0;
            freed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            left_reg  <= left_next;
            have_reg  <= have_next;
            freed_reg <= freed_next;
            if (ctl.clear)
            begin
                used_reg <= '0;
                free_reg <= clear_blocks;
            end
            else
            begin
                used_reg <= used_next;
                free_reg <= free_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        start_reg <= start_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        free_next  = free_reg;
        scan_next  = scan_reg;
        left_next  = left_reg;
        have_next  = have_reg;
        prev_next  = prev_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        freed_next = freed_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = prev_reg;
        wr_data    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                res_next = '{status: ST_BAD, result_block: '0, chain_end: 1'b0,
                             blocks_freed: '0, free_left: CNT_W'(free_reg)};
                if (ctl.start)
                begin
                    state_next = S_DONE;
                    priority if (req.op == OP_ALLOC)
                    begin
                        if (req.block_count == '0)
                        begin
                            res_next.status = ST_BAD;
                        end
                        else if (req.block_count > CNT_W'(free_reg))
                        begin
                            res_next.status = ST_SHORT;
                        end
                        else
                        begin
                            free_next  = free_reg - req.block_count[NW-1:0];
                            left_next  = req.block_count;
                            scan_next  = '0;
                            have_next  = 1'b0;
                            state_next = S_ALLOC_SCAN;
                        end
                    end
                    else if (req.op == OP_FREE)
                    begin
                        if (req_ok)
                        begin
                            cur_next   = req_idx;
                            freed_next = '0;
                            state_next = S_FREE_RD;
                        end
                    end
                    else if (req.op == OP_READ)
                    begin
                        if (req_ok)
                        begin
                            state_next = S_READ_CHK;
                        end
                    end
                    else
                    begin
                        res_next.status = ST_BAD;
                    end
                end
            end

            S_ALLOC_SCAN:
            begin
                if ((scan_reg < blocks) && (left_reg != '0))
                begin
                    if (!used_reg[scan_idx])
                    begin
                        used_next[scan_idx] = 1'b1;
                        if (have_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = prev_reg;
                            wr_data = {1'b0, scan_idx};
                        end
                        else
                        begin
                            start_next = scan_idx;
                        end
                        have_next = 1'b1;
                        prev_next = scan_idx;
                        left_next = left_reg - 1'b1;
                    end
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = S_ALLOC_END;
                end
            end

            S_ALLOC_END:
            begin
                wr_en      = 1'b1;
                wr_addr    = prev_reg;
                wr_data    = {1'b1, {AW{1'b0}}};
                res_next   = '{status: ST_OK, result_block: IDX_W'(start_reg),
                               chain_end: 1'b0, blocks_freed: '0,
                               free_left: CNT_W'(free_reg)};
                state_next = S_DONE;
            end

            S_FREE_RD:
            begin
                if ((freed_reg < blocks) && (NW'(cur_reg) < blocks) && used_reg[cur_reg])
                begin
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    state_next = S_FREE_FIN;
                end
            end

            S_FREE_CHK:
            begin
                used_next[cur_reg] = 1'b0;
                freed_next         = freed_reg + 1'b1;
                if (rd_data_reg[AW])
                begin
                    state_next = S_FREE_FIN;
                end
                else
                begin
                    cur_next   = rd_data_reg[AW-1:0];
                    state_next = S_FREE_RD;
                end
            end

            S_FREE_FIN:
            begin
                free_next  = free_clamp;
                res_next   = '{status: ST_OK, result_block: '0, chain_end: 1'b0,
                               blocks_freed: CNT_W'(freed_reg),
                               free_left: CNT_W'(free_clamp)};
                state_next = S_DONE;
            end

            S_READ_CHK:
            begin
                res_next = '{status: ST_OK, result_block: '0, chain_end: 1'b0,
                             blocks_freed: '0, free_left: CNT_W'(free_reg)};
                if (rd_data_reg[AW])
                begin
                    res_next.chain_end = 1'b1;
                end
                else
                begin
                    res_next.result_block = IDX_W'(rd_data_reg[AW-1:0]);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (ctl.res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

[rtl/chained_block_allocation_table.sv]
// ----------------------------------------------------------------------------
// chained_block_allocation_table
// Linked block allocation table: allocate, free and read chains of blocks.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     op, block_count, block_index
//   out      out_valid / out_stall   status, result_block, chain_end,
//                                    blocks_freed, free_left
//   cfg      cfg_valid / cfg_ready   total_blocks
//
// Allocate scans entries in order (up to n), then marks the chain end;
// free walks the chain, one link RAM read per block released, and stops
// at a free entry or the chain end; read link reads one entry; refused
// requests go straight to the result. n is the effective block count.
// Reset and a cfg write clear the table at once (used flags in flops), no
// sweep. A waiting result sits in the output register while the next item
// is taken; in_stall stays high for the whole of each operation.
// ----------------------------------------------------------------------------
`include "chained_block_allocation_table_defines.svh"

module chained_block_allocation_table
    import cbat_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [OP_W-1:0]  op,
    input  logic [CNT_W-1:0] block_count,
    input  logic [IDX_W-1:0] block_index,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ST_W-1:0]  status,
    output logic [IDX_W-1:0] result_block,
    output logic             chain_end,
    output logic [CNT_W-1:0] blocks_freed,
    output logic [CNT_W-1:0] free_left,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] total_blocks
);

    localparam int MEM_DEPTH = (NUM_BLOCKS < MAX_BLOCKS) ? NUM_BLOCKS : MAX_BLOCKS;
    localparam int NW        = $clog2(MEM_DEPTH + 1);

    logic [NW-1:0] blocks_reg;
    logic [NW-1:0] cfg_blocks;
    logic          out_valid_reg;
    res_t          out_res_reg;
    ctl_t          ctl;
    req_t          req;
    logic          core_idle;
    logic          res_valid;
    res_t          res;

    assign cfg_blocks = (total_blocks > CNT_W'(MEM_DEPTH)) ? NW'(MEM_DEPTH)
                                                          : total_blocks[NW-1:0];

    assign in_stall     = !core_idle;
    assign cfg_ready    = core_idle;
    assign ctl.start    = in_valid && core_idle;
    assign ctl.clear    = cfg_valid && cfg_ready;
    assign ctl.res_take = res_valid && (!out_valid_reg || !out_stall);

    assign req.op          = op;
    assign req.block_count = block_count;
    assign req.block_index = block_index;

    cbat_core #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .req         (req),
        .clear_blocks(cfg_blocks),
        .blocks      (blocks_reg),
        .idle        (core_idle),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg    <= NW'(MEM_DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                blocks_reg <= cfg_blocks;
            end
            if (ctl.res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign result_block = out_res_reg.result_block;
    assign chain_end    = out_res_reg.chain_end;
    assign blocks_freed = out_res_reg.blocks_freed;
    assign free_left    = out_res_reg.free_left;

    `CBAT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
    `CBAT_ASSERT_NOW(a_refused_clean, out_valid && (status != ST_OK), (result_block == '0) && (blocks_freed == '0) && !chain_end, "refused item carries data")
    `CBAT_ASSERT_NOW(a_end_no_link, out_valid && chain_end, (result_block == '0) && (blocks_freed == '0), "chain end with link")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained block allocation table. A directed
// pass covers refusals, chain links, dangling links and an empty disk; then
// random phases at several disk sizes mix well-formed allocate/free/read
// traffic with noise. Each reply is checked field by field against an
// in-bench model of the link table. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
    import cbat_pkg::*;

    localparam int TB_BLOCKS = NUM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int TAIL_CYCLES = 600;
    localparam int NUM_PHASES = 11;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  op = '0;
    logic [CNT_W-1:0] block_count = '0;
    logic [IDX_W-1:0] block_index = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] result_block;
    logic             chain_end;
    logic [CNT_W-1:0] blocks_freed;
    logic [CNT_W-1:0] free_left;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] total_blocks = '0;

    // link table copy
    bit               blk_used [TB_BLOCKS];
    bit               blk_last [TB_BLOCKS];
    logic [IDX_W-1:0] blk_next [TB_BLOCKS];
    int               free_blocks;
    logic [CNT_W-1:0] disk_size;

    res_t             table_replies [$];
    res_t             want_reply;
    logic [IDX_W-1:0] chain_starts [$];
    int               mismatch_count = 0;
    int unsigned      cycle_count = 0;
    bit               idling = 1'b1;
    int               stall_left = 0;

    int phase_size  [NUM_PHASES] = '{16, 256, 1, 8, 511, 2, 32, 0, 64, 5, 256};
    int phase_items [NUM_PHASES] = '{150, 120, 40, 120, 100, 50, 150, 20, 150, 80, 150};

    chained_block_allocation_table #(
        .NUM_BLOCKS(TB_BLOCKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .block_count(block_count),
        .block_index(block_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .result_block(result_block),
        .chain_end(chain_end),
        .blocks_freed(blocks_freed),
        .free_left(free_left),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .total_blocks(total_blocks)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int disk_span();
        int n;
        n = disk_size;
        if (n > MAX_BLOCKS)
            n = MAX_BLOCKS;
        if (n > TB_BLOCKS)
            n = TB_BLOCKS;
        return n;
    endfunction

    function automatic void clear_table(logic [CNT_W-1:0] size);
        disk_size = size;
        for (int k = 0; k < TB_BLOCKS; k++)
        begin
            blk_used[k] = 1'b0;
            blk_last[k] = 1'b0;
            blk_next[k] = '0;
        end
        free_blocks = disk_span();
        chain_starts.delete();
    endfunction

    function automatic res_t run_table_op(logic [OP_W-1:0] o, logic [CNT_W-1:0] c,
                                          logic [IDX_W-1:0] i);
        res_t r;
        int   n;
        int   left;
        int   prev;
        int   cur;
        int   nx;
        int   freed;
        bit   have;
        bit   last;
        n = disk_span();
        r = '0;
        r.status = ST_BAD;
        case (o)
            OP_ALLOC:
            begin
                if (c == 0)
                    r.status = ST_BAD;
                else if (c > free_blocks)
                    r.status = ST_SHORT;
                else
                begin
                    left = c;
                    have = 1'b0;
                    prev = 0;
                    for (int k = 0; k < n && left > 0; k++)
                    begin
                        if (!blk_used[k])
                        begin
                            if (have)
                            begin
                                blk_last[prev] = 1'b0;
                                blk_next[prev] = IDX_W'(k);
                            end
                            else
                            begin
                                r.result_block = IDX_W'(k);
                                have = 1'b1;
                            end
                            blk_used[k] = 1'b1;
                            blk_last[k] = 1'b1;
                            blk_next[k] = '0;
                            prev = k;
                            left--;
                        end
                    end
                    free_blocks = free_blocks - c;
                    r.status = ST_OK;
                end
            end
            OP_FREE:
            begin
                if (i < n && blk_used[i])
                begin
                    cur = i;
                    freed = 0;
                    // stop at a free entry or a link out of range
                    while (freed < n && cur < n && blk_used[cur])
                    begin
                        last = blk_last[cur];
                        nx = blk_next[cur];
                        blk_used[cur] = 1'b0;
                        blk_last[cur] = 1'b0;
                        blk_next[cur] = '0;
                        freed++;
                        if (last)
                            break;
                        cur = nx;
                    end
                    free_blocks = free_blocks + freed;
                    if (free_blocks > n)
                        free_blocks = n;
                    r.status = ST_OK;
                    r.blocks_freed = CNT_W'(freed);
                end
            end
            OP_READ:
            begin
                if (i < n && blk_used[i])
                begin
                    r.status = ST_OK;
                    if (blk_last[i])
                        r.chain_end = 1'b1;
                    else
                        r.result_block = blk_next[i];
                end
            end
            default:
                r.status = ST_BAD;
        endcase
        r.free_left = CNT_W'(free_blocks);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || !idling)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (table_replies.size() == 0)
            begin
                $error("result with no item pending");
                mismatch_count++;
            end
            else
            begin
                want_reply = table_replies.pop_front();
                if (status !== want_reply.status)
                begin
                    $error("status: expected %0d, actual %0d", want_reply.status, status);
                    mismatch_count++;
                end
                if (result_block !== want_reply.result_block)
                begin
                    $error("result_block: expected %0d, actual %0d",
                           want_reply.result_block, result_block);
                    mismatch_count++;
                end
                if (chain_end !== want_reply.chain_end)
                begin
                    $error("chain_end: expected %0d, actual %0d",
                           want_reply.chain_end, chain_end);
                    mismatch_count++;
                end
                if (blocks_freed !== want_reply.blocks_freed)
                begin
                    $error("blocks_freed: expected %0d, actual %0d",
                           want_reply.blocks_freed, blocks_freed);
                    mismatch_count++;
                end
                if (free_left !== want_reply.free_left)
                begin
                    $error("free_left: expected %0d, actual %0d",
                           want_reply.free_left, free_left);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] o, input logic [CNT_W-1:0] c,
                             input logic [IDX_W-1:0] i);
        res_t r;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        op <= o;
        block_count <= c;
        block_index <= i;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = run_table_op(o, c, i);
        table_replies.push_back(r);
        if (o == OP_ALLOC && r.status == ST_OK)
            chain_starts.push_back(r.result_block);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_disk_size(input logic [CNT_W-1:0] size);
        drain_replies();
        cfg_valid <= 1'b1;
        total_blocks <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        clear_table(size);
    endtask

    task automatic random_item();
        int               n;
        int               r;
        int               k;
        logic [OP_W-1:0]  o;
        logic [CNT_W-1:0] c;
        logic [IDX_W-1:0] i;
        n = disk_span();
        r = $urandom_range(0, 99);
        c = CNT_W'($urandom_range(0, 511));
        i = IDX_W'($urandom_range(0, 255));
        if (r < 40)
        begin
            o = OP_ALLOC;
            if (free_blocks == 0)
                c = CNT_W'($urandom_range(1, 3));
            else if ($urandom_range(0, 9) == 0)
                c = CNT_W'($urandom_range(1, free_blocks));
            else
                c = CNT_W'($urandom_range(1, (free_blocks < 8) ? free_blocks : 8));
        end
        else if (r < 65)
        begin
            o = OP_FREE;
            // free from inside a chain now and then to leave dangling links
            if (chain_starts.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                k = $urandom_range(0, chain_starts.size() - 1);
                i = chain_starts[k];
                chain_starts.delete(k);
            end
            else if (n != 0)
                i = IDX_W'($urandom_range(0, n - 1));
        end
        else if (r < 85)
        begin
            o = OP_READ;
            if (n != 0)
                i = IDX_W'($urandom_range(0, n - 1));
        end
        else
            o = OP_W'($urandom_range(0, 3));
        send_item(o, c, i);
    endtask

    task automatic test_directed_ops();
        send_item(OP_ALLOC, 9'd0, 8'd0);
        send_item(OP_ALLOC, 9'd511, 8'd0);
        send_item(OP_ALLOC, 9'd257, 8'd255);
        send_item(OP_ALLOC, 9'd1, 8'd0);
        send_item(OP_ALLOC, 9'd5, 8'd0);
        send_item(OP_READ, 9'd0, 8'd0);
        send_item(OP_READ, 9'd0, 8'd1);
        send_item(OP_READ, 9'd0, 8'd5);
        send_item(OP_READ, 9'd0, 8'd255);
        send_item(OP_FREE, 9'd0, 8'd200);
        send_item(OP_UNUSED, 9'd511, 8'd255);
        // cut a chain in the middle, then walk into the blocks reused after it
        send_item(OP_FREE, 9'd0, 8'd3);
        send_item(OP_READ, 9'd0, 8'd2);
        send_item(OP_ALLOC, 9'd2, 8'd0);
        send_item(OP_FREE, 9'd0, 8'd1);
        send_item(OP_FREE, 9'd0, 8'd0);
        send_item(OP_ALLOC, 9'd256, 8'd0);
        send_item(OP_READ, 9'd0, 8'd255);
        send_item(OP_READ, 9'd0, 8'd128);
        send_item(OP_FREE, 9'd0, 8'd0);
    endtask

    task automatic test_empty_disk();
        set_disk_size(9'd0);
        send_item(OP_ALLOC, 9'd1, 8'd0);
        send_item(OP_ALLOC, 9'd0, 8'd0);
        send_item(OP_READ, 9'd0, 8'd0);
        send_item(OP_FREE, 9'd0, 8'd0);
        set_disk_size(9'd1);
        send_item(OP_ALLOC, 9'd2, 8'd0);
        send_item(OP_ALLOC, 9'd1, 8'd0);
        send_item(OP_READ, 9'd0, 8'd0);
        send_item(OP_FREE, 9'd0, 8'd0);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_disk_size(CNT_W'(phase_size[p]));
            // hold the last phase free of idling
            if (p == NUM_PHASES - 1)
                idling = 1'b0;
            else
                idling = ($urandom_range(0, 3) != 0);
            repeat (phase_items[p]) random_item();
        end
    endtask

    initial
    begin
        clear_table(9'd256);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_empty_disk();
        test_random_phases();
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && table_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
